[hw/rtl/tps_pkg.sv]
// Package for the tick process scheduler: shared types, codes and constants.
// No dependencies.
`default_nettype none
package tps_pkg;
    localparam int unsigned QPEND = 0;
    localparam int unsigned QDEVA = 1;
    localparam int unsigned QDEVB = 2;
    localparam int unsigned QRDY  = 3;

    localparam logic FUNC_ADMIT = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;
    localparam logic [1:0] CFG_DECR    = 2'd2;

    localparam logic signed [6:0] PRIO_FLOOR = -7'sd64;
    localparam logic [3:0] SLICE_MAX = 4'd15;

    typedef struct packed {
        logic        func;
        logic [3:0]  proc_id;
        logic [15:0] arrival_time;
        logic [5:0]  start_priority;
        logic [7:0]  cpu_need;
        logic [7:0]  io_need;
        logic        io_device;
        logic [15:0] tick_time;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [3:0]  cpu_pid;
        logic        cpu_active;
        logic [3:0]  done_pid;
        logic        done_valid;
        logic [3:0]  io_a_pid;
        logic        io_a_active;
        logic [3:0]  io_b_pid;
        logic        io_b_active;
        logic [31:0] cpu_busy_total;
        logic [31:0] io_a_busy_total;
        logic [31:0] io_b_busy_total;
    } t_result;
endpackage
`default_nettype wire

[hw/rtl/tps_front.sv]
// Front end: two-entry queue of input items.
// Depends on tps_pkg.
`default_nettype none
module tps_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  tps_pkg::t_item i_item,
    output logic           o_valid,
    input  wire            i_take,
    output tps_pkg::t_item o_item
);
    tps_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_take;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[hw/rtl/tps_back.sv]
// Back end: sequencer that runs admits and ticks over the slot tables
// and linked queues, one list step per cycle. Depends on tps_pkg.
`default_nettype none
module tps_back #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_take,
    input  tps_pkg::t_item  i_item,
    input  wire [1:0]       i_mode,
    input  wire [3:0]       i_quantum,
    input  wire [3:0]       i_decr,
    output logic            o_valid,
    input  wire             i_ready,
    output tps_pkg::t_result o_res
);
    localparam int unsigned SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned LW = $clog2(MAX_PROCS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PWALK, S_REL, S_DEVA, S_DEVB, S_CPU, S_POST,
        S_RWALK, S_OUT
    } t_state;

    t_state r_state;
    logic [15:0] r_arr [MAX_PROCS];
    logic signed [6:0] r_pri [MAX_PROCS];
    logic [7:0] r_cpu [MAX_PROCS];
    logic [7:0] r_io [MAX_PROCS];
    logic r_dev [MAX_PROCS];
    logic [3:0] r_slc [MAX_PROCS];
    logic [SW-1:0] r_lnk [MAX_PROCS];
    logic [3:0] r_pid [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_free;
    logic [SW-1:0] r_hd [4];
    logic [SW-1:0] r_tl [4];
    logic [LW-1:0] r_len [4];
    logic [31:0] r_bc [3];

    tps_pkg::t_item r_it;
    tps_pkg::t_result r_res;
    logic [SW-1:0] r_s, r_cur;
    logic [LW-1:0] r_i;
    logic r_ret;     // walk then returns to the stage after its device stage (ready insert)
    logic r_retb;    // walk came from device B stage

    logic found;
    logic [SW-1:0] fslot;
    always_comb begin
        found = 1'b0;
        fslot = '0;
        for (int k = MAX_PROCS - 1; k >= 0; k--) begin
            if (r_free[k]) begin
                found = 1'b1;
                fslot = SW'(k);
            end
        end
    end

    assign o_take = (r_state == S_IDLE) && !o_valid;
    assign o_res = r_res;

    logic [SW-1:0] hd_r, nxt_c, s_h;
    logic signed [7:0] pdec;
    logic signed [6:0] pnew;
    logic [7:0] cl;
    logic [SW-1:0] lh;
    always_comb begin
        hd_r = r_hd[tps_pkg::QRDY];
        nxt_c = r_lnk[r_cur];
        s_h = r_hd[tps_pkg::QPEND];
        pdec = 8'(r_pri[hd_r]) - 8'({4'd0, i_decr});
        pnew = (pdec < 8'(tps_pkg::PRIO_FLOOR)) ? tps_pkg::PRIO_FLOOR : 7'(pdec);
        cl = r_cpu[hd_r] - 8'd1;
        lh = r_lnk[hd_r];
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        bump = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_free <= '1;
            for (int q = 0; q < 4; q++) begin
                r_hd[q] <= '0;
                r_tl[q] <= '0;
                r_len[q] <= '0;
            end
            for (int k = 0; k < 3; k++) r_bc[k] <= '0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_take) begin
                        r_it <= i_item;
                        if (i_item.func == tps_pkg::FUNC_ADMIT && !found) begin
                            r_res <= '{status: 1'b1, default: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_res <= '0;
                            if (i_item.func == tps_pkg::FUNC_ADMIT) begin
                                r_free[fslot] <= 1'b0;
                                r_pid[fslot] <= i_item.proc_id;
                                r_arr[fslot] <= i_item.arrival_time;
                                r_pri[fslot] <= 7'({1'b0, i_item.start_priority});
                                r_cpu[fslot] <= (i_item.cpu_need == 8'd0) ? 8'd1
                                                : i_item.cpu_need;
                                r_io[fslot] <= (i_item.io_need == 8'd0) ? 8'd1
                                               : i_item.io_need;
                                r_dev[fslot] <= i_item.io_device;
                                r_slc[fslot] <= '0;
                                r_s <= fslot;
                                if (r_len[tps_pkg::QPEND] == '0 ||
                                    i_item.arrival_time < r_arr[s_h]) begin
                                    r_lnk[fslot] <= s_h;
                                    if (r_len[tps_pkg::QPEND] == '0)
                                        r_tl[tps_pkg::QPEND] <= fslot;
                                    r_hd[tps_pkg::QPEND] <= fslot;
                                    r_len[tps_pkg::QPEND] <= r_len[tps_pkg::QPEND] + 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_cur <= s_h;
                                    r_i <= LW'(1);
                                    r_state <= S_PWALK;
                                end
                            end else begin
                                r_state <= S_REL;
                            end
                        end
                    end
                end
                S_PWALK: begin
                    if (r_i < r_len[tps_pkg::QPEND] && r_arr[nxt_c] <= r_arr[r_s]) begin
                        r_cur <= nxt_c;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_lnk[r_s] <= nxt_c;
                        r_lnk[r_cur] <= r_s;
                        if (r_cur == r_tl[tps_pkg::QPEND]) r_tl[tps_pkg::QPEND] <= r_s;
                        r_len[tps_pkg::QPEND] <= r_len[tps_pkg::QPEND] + 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_REL: begin
                    if (r_len[tps_pkg::QPEND] != '0 && r_arr[s_h] == r_it.tick_time) begin
                        if (r_len[tps_pkg::QPEND] > LW'(1))
                            r_hd[tps_pkg::QPEND] <= r_lnk[s_h];
                        r_len[tps_pkg::QPEND] <= r_len[tps_pkg::QPEND] - 1'b1;
                        if (r_dev[s_h]) begin
                            if (r_len[tps_pkg::QDEVB] == '0) r_hd[tps_pkg::QDEVB] <= s_h;
                            else r_lnk[r_tl[tps_pkg::QDEVB]] <= s_h;
                            r_tl[tps_pkg::QDEVB] <= s_h;
                            r_len[tps_pkg::QDEVB] <= r_len[tps_pkg::QDEVB] + 1'b1;
                        end else begin
                            if (r_len[tps_pkg::QDEVA] == '0) r_hd[tps_pkg::QDEVA] <= s_h;
                            else r_lnk[r_tl[tps_pkg::QDEVA]] <= s_h;
                            r_tl[tps_pkg::QDEVA] <= s_h;
                            r_len[tps_pkg::QDEVA] <= r_len[tps_pkg::QDEVA] + 1'b1;
                        end
                    end else begin
                        r_state <= S_DEVA;
                    end
                end
                S_DEVA, S_DEVB: begin
                    logic [SW-1:0] s;
                    logic [7:0] il;
                    logic qb;
                    t_state nst;
                    qb = (r_state == S_DEVB);
                    s = qb ? r_hd[tps_pkg::QDEVB] : r_hd[tps_pkg::QDEVA];
                    il = r_io[s] - 8'd1;
                    nst = qb ? S_CPU : S_DEVB;
                    if ((qb ? r_len[tps_pkg::QDEVB] : r_len[tps_pkg::QDEVA]) != '0) begin
                        r_io[s] <= il;
                        if (qb) begin
                            r_bc[2] <= bump(r_bc[2]);
                            r_res.io_b_pid <= r_pid[s];
                            r_res.io_b_active <= 1'b1;
                        end else begin
                            r_bc[1] <= bump(r_bc[1]);
                            r_res.io_a_pid <= r_pid[s];
                            r_res.io_a_active <= 1'b1;
                        end
                        if (il == 8'd0) begin
                            if (qb) begin
                                if (r_len[tps_pkg::QDEVB] > LW'(1))
                                    r_hd[tps_pkg::QDEVB] <= r_lnk[s];
                                r_len[tps_pkg::QDEVB] <= r_len[tps_pkg::QDEVB] - 1'b1;
                            end else begin
                                if (r_len[tps_pkg::QDEVA] > LW'(1))
                                    r_hd[tps_pkg::QDEVA] <= r_lnk[s];
                                r_len[tps_pkg::QDEVA] <= r_len[tps_pkg::QDEVA] - 1'b1;
                            end
                            r_slc[s] <= '0;
                            if (i_mode != tps_pkg::MODE_PRIO) begin
                                if (r_len[tps_pkg::QRDY] == '0) r_hd[tps_pkg::QRDY] <= s;
                                else r_lnk[r_tl[tps_pkg::QRDY]] <= s;
                                r_tl[tps_pkg::QRDY] <= s;
                                r_len[tps_pkg::QRDY] <= r_len[tps_pkg::QRDY] + 1'b1;
                            end else if (r_len[tps_pkg::QRDY] == '0 ||
                                         r_pri[s] > r_pri[hd_r]) begin
                                r_lnk[s] <= hd_r;
                                if (r_len[tps_pkg::QRDY] == '0) r_tl[tps_pkg::QRDY] <= s;
                                r_hd[tps_pkg::QRDY] <= s;
                                r_len[tps_pkg::QRDY] <= r_len[tps_pkg::QRDY] + 1'b1;
                            end else begin
                                r_s <= s;
                                r_cur <= hd_r;
                                r_i <= LW'(1);
                                r_ret <= 1'b1;
                                r_retb <= qb;
                                nst = S_RWALK;
                            end
                        end
                    end
                    r_state <= nst;
                end
                S_CPU: begin
                    if (r_len[tps_pkg::QRDY] != '0) begin
                        r_cpu[hd_r] <= cl;
                        r_bc[0] <= bump(r_bc[0]);
                        r_res.cpu_pid <= r_pid[hd_r];
                        r_res.cpu_active <= 1'b1;
                        if (i_mode == tps_pkg::MODE_RR && r_slc[hd_r] < tps_pkg::SLICE_MAX)
                            r_slc[hd_r] <= r_slc[hd_r] + 4'd1;
                        if (i_mode == tps_pkg::MODE_PRIO) r_pri[hd_r] <= pnew;
                        if (cl == 8'd0) begin
                            if (r_len[tps_pkg::QRDY] > LW'(1)) r_hd[tps_pkg::QRDY] <= lh;
                            r_len[tps_pkg::QRDY] <= r_len[tps_pkg::QRDY] - 1'b1;
                            r_free[hd_r] <= 1'b1;
                            r_res.done_pid <= r_pid[hd_r];
                            r_res.done_valid <= 1'b1;
                        end
                        r_state <= S_POST;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POST: begin
                    t_state nst;
                    nst = S_OUT;
                    if (r_len[tps_pkg::QRDY] > LW'(1)) begin
                        if (i_mode == tps_pkg::MODE_RR && r_slc[hd_r] >= i_quantum) begin
                            r_hd[tps_pkg::QRDY] <= lh;
                            r_slc[hd_r] <= '0;
                            r_lnk[r_tl[tps_pkg::QRDY]] <= hd_r;
                            r_tl[tps_pkg::QRDY] <= hd_r;
                        end else if (i_mode == tps_pkg::MODE_PRIO &&
                                     r_pri[hd_r] < r_pri[lh]) begin
                            r_hd[tps_pkg::QRDY] <= lh;
                            r_len[tps_pkg::QRDY] <= r_len[tps_pkg::QRDY] - 1'b1;
                            r_s <= hd_r;
                            r_cur <= lh;
                            r_i <= LW'(1);
                            r_ret <= 1'b0;
                            nst = S_RWALK;
                        end
                    end
                    r_state <= nst;
                end
                S_RWALK: begin
                    if (r_i < r_len[tps_pkg::QRDY] && r_pri[nxt_c] > r_pri[r_s]) begin
                        r_cur <= nxt_c;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_lnk[r_s] <= nxt_c;
                        r_lnk[r_cur] <= r_s;
                        if (r_cur == r_tl[tps_pkg::QRDY]) r_tl[tps_pkg::QRDY] <= r_s;
                        r_len[tps_pkg::QRDY] <= r_len[tps_pkg::QRDY] + 1'b1;
                        r_state <= !r_ret ? S_OUT : (r_retb ? S_CPU : S_DEVB);
                    end
                end
                S_OUT: begin
                    r_res.cpu_busy_total <= r_bc[0];
                    r_res.io_a_busy_total <= r_bc[1];
                    r_res.io_b_busy_total <= r_bc[2];
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/tick_process_scheduler.sv]
// Top level of the tick process scheduler: config registers, front queue,
// back-end sequencer. Depends on tps_pkg, tps_front, tps_back.
//
// Usage: s_axis carries admit or tick words (tuser selects which); m_axis
// returns one result word per input word. Config must be written through
// i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block does not enforce
// this. An admit that lands at the pending head gives its result without a
// list walk, otherwise after walking the pending entries. A tick releases
// processes, serves devices A and B and the CPU, and can make up to three
// priority insertions into ready, each of which may walk the ready entries.
// The sequencer walks its lists a single step at a time. The next word is
// taken the cycle after the result is accepted; the front queue holds up to
// two words meanwhile. The result stays in its register while m_axis_tready
// is low, and the back end waits. Reset clears all queues, frees all slots,
// zeroes the busy counters and loads config defaults (FIFO, quantum 2,
// decrement 3).
`default_nettype none
module tick_process_scheduler #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // func
    input  wire         s_axis_tuser,
    // proc_id, arrival_time, start_priority, cpu_need, io_need,
    // io_device, tick_time, zero pad
    input  wire [63:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status, cpu_pid, cpu_active, done_pid, done_valid, io_a_pid,
    // io_a_active, io_b_pid, io_b_active, cpu_busy_total, io_a_busy_total,
    // io_b_busy_total, zero pad
    output logic [119:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire [1:0]   i_cfg_idx,
    input  wire [3:0]   i_cfg_data
);
    logic [1:0] r_mode;
    logic [3:0] r_quant, r_decr;
    tps_pkg::t_item in_item, q_item;
    tps_pkg::t_result res;
    logic q_valid, q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tps_pkg::MODE_FIFO;
            r_quant <= 4'd2;
            r_decr <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tps_pkg::CFG_MODE:    r_mode <= i_cfg_data[1:0];
                tps_pkg::CFG_QUANTUM: r_quant <= i_cfg_data;
                tps_pkg::CFG_DECR:    r_decr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.func = s_axis_tuser;
    assign in_item.proc_id = s_axis_tdata[3:0];
    assign in_item.arrival_time = s_axis_tdata[19:4];
    assign in_item.start_priority = s_axis_tdata[25:20];
    assign in_item.cpu_need = s_axis_tdata[33:26];
    assign in_item.io_need = s_axis_tdata[41:34];
    assign in_item.io_device = s_axis_tdata[42];
    assign in_item.tick_time = s_axis_tdata[58:43];

    tps_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_take(q_take), .o_item(q_item)
    );

    tps_back #(.MAX_PROCS(MAX_PROCS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_take(q_take), .i_item(q_item),
        .i_mode(r_mode), .i_quantum(r_quant), .i_decr(r_decr),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {3'b0, res.io_b_busy_total, res.io_a_busy_total,
                           res.cpu_busy_total, res.io_b_active, res.io_b_pid,
                           res.io_a_active, res.io_a_pid, res.done_valid,
                           res.done_pid, res.cpu_active, res.cpu_pid, res.status};

    a_pid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.cpu_active |-> res.cpu_pid == 4'd0)
        else $error("cpu pid without activity");
    a_done_cpu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.done_valid |-> res.cpu_active && res.done_pid == res.cpu_pid)
        else $error("retire without cpu run");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.status |-> !res.cpu_active && !res.io_a_active)
        else $error("refused admit with activity");
endmodule
`default_nettype wire

[tb/tick_process_scheduler_check.sv]
// Checker for the tick process scheduler: watches config writes and both stream
// channels, predicts each result word and compares it field by field.
// Depends on tps_pkg.
`timescale 1ns / 1ps
module tick_process_scheduler_check (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire          i_in_ready,
    input  wire          i_in_user,
    input  wire [63:0]   i_in_data,
    input  wire          i_out_valid,
    input  wire          i_out_ready,
    input  wire [119:0]  i_out_data,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_idx,
    input  wire [3:0]    i_cfg_data,
    output int           o_fail_count,
    output int           o_outstanding
);
    localparam int NSLOT = 16;

    logic [15:0] arr_tab   [NSLOT];
    int          prio_tab  [NSLOT];
    logic [7:0]  cpu_tab   [NSLOT];
    logic [7:0]  io_tab    [NSLOT];
    logic        dev_tab   [NSLOT];
    logic [3:0]  slice_tab [NSLOT];
    logic [3:0]  link_tab  [NSLOT];
    logic [3:0]  pid_tab   [NSLOT];
    logic        slot_open [NSLOT];
    logic [3:0]  qhead [4];
    logic [3:0]  qtail [4];
    int          qlen  [4];
    logic [31:0] busy  [3];
    logic [1:0]  mode;
    logic [3:0]  quantum;
    logic [3:0]  decr;

    tps_pkg::t_result expected_words[$];

    function automatic void busy_inc(int k);
        if (busy[k] != 32'hFFFF_FFFF) busy[k] = busy[k] + 32'd1;
    endfunction

    function automatic void q_append(int q, logic [3:0] s);
        if (qlen[q] == 0) qhead[q] = s;
        else link_tab[qtail[q]] = s;
        qtail[q] = s;
        qlen[q]++;
    endfunction

    function automatic void q_front(int q, logic [3:0] s);
        link_tab[s] = qhead[q];
        if (qlen[q] == 0) qtail[q] = s;
        qhead[q] = s;
        qlen[q]++;
    endfunction

    function automatic void q_after(int q, logic [3:0] cur, logic [3:0] s);
        link_tab[s] = link_tab[cur];
        link_tab[cur] = s;
        if (cur == qtail[q]) qtail[q] = s;
        qlen[q]++;
    endfunction

    function automatic logic [3:0] q_pop(int q);
        logic [3:0] s;
        s = qhead[q];
        if (qlen[q] > 1) qhead[q] = link_tab[s];
        qlen[q]--;
        return s;
    endfunction

    function automatic void ready_by_priority(logic [3:0] s);
        logic [3:0] cur;
        if (qlen[tps_pkg::QRDY] == 0 || prio_tab[s] > prio_tab[qhead[tps_pkg::QRDY]]) begin
            q_front(tps_pkg::QRDY, s);
            return;
        end
        cur = qhead[tps_pkg::QRDY];
        for (int i = 1; i < qlen[tps_pkg::QRDY] && prio_tab[link_tab[cur]] > prio_tab[s]; i++)
            cur = link_tab[cur];
        q_after(tps_pkg::QRDY, cur, s);
    endfunction

    function automatic void pending_by_arrival(logic [3:0] s);
        logic [3:0] cur;
        if (qlen[tps_pkg::QPEND] == 0 || arr_tab[s] < arr_tab[qhead[tps_pkg::QPEND]]) begin
            q_front(tps_pkg::QPEND, s);
            return;
        end
        cur = qhead[tps_pkg::QPEND];
        for (int i = 1; i < qlen[tps_pkg::QPEND] && arr_tab[link_tab[cur]] <= arr_tab[s]; i++)
            cur = link_tab[cur];
        q_after(tps_pkg::QPEND, cur, s);
    endfunction

    function automatic void join_ready(logic [3:0] s);
        slice_tab[s] = '0;
        if (mode == tps_pkg::MODE_PRIO) ready_by_priority(s);
        else q_append(tps_pkg::QRDY, s);
    endfunction

    function automatic void serve_device(int q, int k, inout logic [3:0] pid, inout logic act);
        logic [3:0] s;
        if (qlen[q] == 0) return;
        s = qhead[q];
        io_tab[s] = io_tab[s] - 8'd1;
        busy_inc(k);
        pid = pid_tab[s];
        act = 1'b1;
        if (io_tab[s] == 0) begin
            void'(q_pop(q));
            join_ready(s);
        end
    endfunction

    function automatic tps_pkg::t_result schedule_word(logic func, logic [63:0] d);
        tps_pkg::t_result r;
        logic [3:0] s;
        logic [3:0] h;
        logic [3:0] cur;
        logic [15:0] now;
        int p;
        int found;
        r = '0;
        if (func == tps_pkg::FUNC_ADMIT) begin
            found = -1;
            for (int i = NSLOT - 1; i >= 0; i--) if (slot_open[i]) found = i;
            if (found < 0) begin
                r.status = 1'b1;
            end else begin
                s = found[3:0];
                slot_open[s] = 1'b0;
                pid_tab[s] = d[3:0];
                arr_tab[s] = d[19:4];
                prio_tab[s] = int'(d[25:20]);
                cpu_tab[s] = (d[33:26] == 8'd0) ? 8'd1 : d[33:26];
                io_tab[s] = (d[41:34] == 8'd0) ? 8'd1 : d[41:34];
                dev_tab[s] = d[42];
                slice_tab[s] = '0;
                pending_by_arrival(s);
            end
        end else begin
            now = d[58:43];
            while (qlen[tps_pkg::QPEND] > 0 && arr_tab[qhead[tps_pkg::QPEND]] == now) begin
                s = q_pop(tps_pkg::QPEND);
                q_append(dev_tab[s] ? tps_pkg::QDEVB : tps_pkg::QDEVA, s);
            end
            serve_device(tps_pkg::QDEVA, 1, r.io_a_pid, r.io_a_active);
            serve_device(tps_pkg::QDEVB, 2, r.io_b_pid, r.io_b_active);
            if (qlen[tps_pkg::QRDY] > 0) begin
                s = qhead[tps_pkg::QRDY];
                cpu_tab[s] = cpu_tab[s] - 8'd1;
                busy_inc(0);
                r.cpu_pid = pid_tab[s];
                r.cpu_active = 1'b1;
                if (mode == tps_pkg::MODE_RR && slice_tab[s] < tps_pkg::SLICE_MAX)
                    slice_tab[s] = slice_tab[s] + 4'd1;
                if (mode == tps_pkg::MODE_PRIO) begin
                    p = prio_tab[s] - int'(decr);
                    prio_tab[s] = (p < -64) ? -64 : p;
                end
                if (cpu_tab[s] == 0) begin
                    void'(q_pop(tps_pkg::QRDY));
                    slot_open[s] = 1'b1;
                    r.done_pid = pid_tab[s];
                    r.done_valid = 1'b1;
                end
                if (qlen[tps_pkg::QRDY] > 1) begin
                    h = qhead[tps_pkg::QRDY];
                    if (mode == tps_pkg::MODE_RR && slice_tab[h] >= quantum) begin
                        void'(q_pop(tps_pkg::QRDY));
                        slice_tab[h] = '0;
                        q_append(tps_pkg::QRDY, h);
                    end else if (mode == tps_pkg::MODE_PRIO &&
                                 prio_tab[h] < prio_tab[link_tab[h]]) begin
                        void'(q_pop(tps_pkg::QRDY));
                        cur = qhead[tps_pkg::QRDY];
                        for (int i = 1; i < qlen[tps_pkg::QRDY] &&
                                prio_tab[link_tab[cur]] > prio_tab[h]; i++)
                            cur = link_tab[cur];
                        q_after(tps_pkg::QRDY, cur, h);
                    end
                end
            end
        end
        r.cpu_busy_total = busy[0];
        r.io_a_busy_total = busy[1];
        r.io_b_busy_total = busy[2];
        return r;
    endfunction

    function automatic tps_pkg::t_result unpack_result(logic [119:0] d);
        tps_pkg::t_result r;
        r.status = d[0];
        r.cpu_pid = d[4:1];
        r.cpu_active = d[5];
        r.done_pid = d[9:6];
        r.done_valid = d[10];
        r.io_a_pid = d[14:11];
        r.io_a_active = d[15];
        r.io_b_pid = d[19:16];
        r.io_b_active = d[20];
        r.cpu_busy_total = d[52:21];
        r.io_a_busy_total = d[84:53];
        r.io_b_busy_total = d[116:85];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_outstanding = expected_words.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        tps_pkg::t_result e;
        tps_pkg::t_result a;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                slot_open[i] = 1'b1;
                arr_tab[i] = 0; prio_tab[i] = 0; cpu_tab[i] = 0; io_tab[i] = 0;
                dev_tab[i] = 0; slice_tab[i] = 0; link_tab[i] = 0; pid_tab[i] = 0;
            end
            for (int q = 0; q < 4; q++) begin
                qhead[q] = 0; qtail[q] = 0; qlen[q] = 0;
            end
            for (int k = 0; k < 3; k++) busy[k] = 0;
            mode = tps_pkg::MODE_FIFO;
            quantum = 4'd2;
            decr = 4'd3;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tps_pkg::CFG_MODE:    mode = i_cfg_data[1:0];
                    tps_pkg::CFG_QUANTUM: quantum = i_cfg_data;
                    tps_pkg::CFG_DECR:    decr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                a = unpack_result(i_out_data);
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: %0h", i_out_data);
                    o_fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    check_field("status", e.status, a.status);
                    check_field("cpu_pid", e.cpu_pid, a.cpu_pid);
                    check_field("cpu_active", e.cpu_active, a.cpu_active);
                    check_field("done_pid", e.done_pid, a.done_pid);
                    check_field("done_valid", e.done_valid, a.done_valid);
                    check_field("io_a_pid", e.io_a_pid, a.io_a_pid);
                    check_field("io_a_active", e.io_a_active, a.io_a_active);
                    check_field("io_b_pid", e.io_b_pid, a.io_b_pid);
                    check_field("io_b_active", e.io_b_active, a.io_b_active);
                    check_field("cpu_busy_total", e.cpu_busy_total, a.cpu_busy_total);
                    check_field("io_a_busy_total", e.io_a_busy_total, a.io_a_busy_total);
                    check_field("io_b_busy_total", e.io_b_busy_total, a.io_b_busy_total);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(schedule_word(i_in_user, i_in_data));
        end
    end
endmodule

[tb/tick_process_scheduler_test.sv]
// Top of the tick process scheduler testbench: clock, reset, admit/tick
// stimulus, config phases and verdict. Depends on tps_pkg, the block and
// tick_process_scheduler_check.
`timescale 1ns / 1ps
module tick_process_scheduler_test;
    localparam int WATCHDOG = 20000;
    localparam int SETTLE = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    wire          s_axis_tready;
    logic         s_axis_tuser;
    logic [63:0]  s_axis_tdata;
    wire          m_axis_tvalid;
    logic         m_axis_tready;
    wire  [119:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [3:0]   i_cfg_data;
    int           fail_count;
    int           outstanding;

    int           stall_pct;
    int           gap_pct;
    int           stall_left;
    int           idle_cycles;
    logic [15:0]  now;
    logic [15:0]  far_arrivals[$];

    tick_process_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    tick_process_scheduler_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_user(s_axis_tuser), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_gap(stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(logic u, logic [63:0] d);
        int gap;
        gap = pick_gap(gap_pct);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= u;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic admit(logic [3:0] pid, logic [15:0] arr, logic [5:0] prio,
                         logic [7:0] cpu, logic [7:0] io, logic dev);
        if (arr >= 64) far_arrivals.push_back(arr);
        send_word(tps_pkg::FUNC_ADMIT, {5'b0, 16'd0, dev, io, cpu, prio, arr, pid});
    endtask

    task automatic tick_at(logic [15:0] t);
        send_word(tps_pkg::FUNC_TICK, {5'b0, t, 1'b0, 8'd0, 8'd0, 6'd0, 16'd0, 4'd0});
    endtask

    task automatic tick_next();
        if (far_arrivals.size() > 0 && $urandom_range(5) == 0) begin
            tick_at(far_arrivals.pop_front());
        end else begin
            now = (now + 16'd1) % 16'd64;
            tick_at(now);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_items(int n);
        logic [7:0] cpu;
        logic [7:0] io;
        logic [15:0] arr;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 45) begin
                case ($urandom_range(19))
                    0: cpu = 8'd0;
                    1: cpu = 8'($urandom_range(255, 128));
                    default: cpu = 8'($urandom_range(6, 1));
                endcase
                case ($urandom_range(19))
                    0: io = 8'd0;
                    1: io = 8'($urandom_range(255, 128));
                    default: io = 8'($urandom_range(5, 1));
                endcase
                case ($urandom_range(19))
                    0: arr = 16'($urandom_range(65535));
                    1: arr = (now + 16'd63) % 16'd64;
                    default: arr = (now + 16'($urandom_range(6))) % 16'd64;
                endcase
                admit(4'($urandom_range(15)), arr, 6'($urandom_range(63)), cpu, io,
                      1'($urandom_range(1)));
            end else begin
                tick_next();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        stall_pct = 0;
        gap_pct = 0;
        now = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, full table and refusal, then drain everything
        admit(4'd15, 16'd65535, 6'd63, 8'd255, 8'd255, 1'b1);
        admit(4'd0, 16'd0, 6'd0, 8'd0, 8'd0, 1'b0);
        for (int i = 0; i < 15; i++)
            admit(i[3:0], 16'd100 + i[15:0], 6'($urandom_range(63)), 8'd1, 8'd1, i[0]);
        admit(4'd7, 16'd5, 6'd10, 8'd1, 8'd1, 1'b0);
        tick_at(16'd1);
        tick_at(16'd0);
        tick_at(16'd0);
        tick_at(16'd65535);
        tick_at(16'd0);
        for (int i = 0; i < 3; i++) tick_next();
        drain();

        stall_pct = 25;
        gap_pct = 25;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(tps_pkg::CFG_MODE, tps_pkg::MODE_RR);
                    write_reg(tps_pkg::CFG_QUANTUM, 4'd1);
                end
                1: begin
                    write_reg(tps_pkg::CFG_QUANTUM, 4'd15);
                    write_reg(tps_pkg::CFG_DECR, 4'd0);
                end
                2: begin
                    write_reg(tps_pkg::CFG_MODE, tps_pkg::MODE_PRIO);
                    write_reg(tps_pkg::CFG_DECR, 4'd15);
                    stall_pct = 0; gap_pct = 0;
                end
                3: begin
                    write_reg(tps_pkg::CFG_MODE, 2'd3); write_reg(tps_pkg::CFG_QUANTUM, 4'd0);
                    stall_pct = 60; gap_pct = 40;
                end
                default: begin
                    write_reg(tps_pkg::CFG_MODE, tps_pkg::MODE_PRIO);
                    write_reg(tps_pkg::CFG_DECR, 4'd3);
                    stall_pct = 20; gap_pct = 20;
                end
            endcase
            random_items(ph == 2 ? 200 : 150);
            drain();
            write_reg(tps_pkg::CFG_MODE, tps_pkg::MODE_RR);
            write_reg(tps_pkg::CFG_QUANTUM, 4'd2);
            random_items(ph == 2 ? 200 : 150);
            for (int i = 0; i < 20; i++) tick_next();
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[tick_process_scheduler.f]
hw/rtl/tps_pkg.sv
hw/rtl/tps_front.sv
hw/rtl/tps_back.sv
hw/rtl/tick_process_scheduler.sv
tb/tick_process_scheduler_check.sv
tb/tick_process_scheduler_test.sv
